>>> hw/rtl/periodic_task_timer_table_macros.svh
// Assertion helpers for the timer table RTL.
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  localparam int ID_W     = 4;
  localparam int ID_COUNT = 16;
  localparam int FUNC_W   = 2;
  localparam int FIELD_W  = 32;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    task_id;
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] now;
  } cmd_word_t;

  typedef struct packed {
    logic [ID_W-1:0] fired_task;
    logic            last_of_run;
  } res_word_t;

  // Fire event from the sequencer; flush closes a tick.
  typedef struct packed {
    logic            valid;
    logic            flush;
    logic [ID_W-1:0] task_id;
  } evt_t;

endpackage

>>> hw/rtl/ptt_ram.sv
module ptt_ram #(
  parameter int DEPTH = ptt_pkg::TASK_SLOTS_DEF,
  parameter int WIDTH = ptt_pkg::ID_W
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ptt_out.sv
`include "periodic_task_timer_table_macros.svh"

module ptt_out (
  input  logic                  clk,
  input  logic                  rst,
  input  ptt_pkg::evt_t         evt,
  output logic                  evt_ready,
  output logic                  res_valid,
  input  logic                  res_stall,
  output ptt_pkg::res_word_t    res
);

  logic                     hold_valid;
  logic [ptt_pkg::ID_W-1:0] hold_id;
  logic                     can_push;
  logic                     take;
  logic                     push;

  // One fire is held back until the next one or the flush tells whether it is last.
  assign can_push  = !res_valid || !res_stall;
  assign evt_ready = !hold_valid || can_push;
  assign take      = evt.valid && evt_ready;
  assign push      = take && hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (take) begin
        hold_valid <= !evt.flush;
      end
      if (push) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !evt.flush) begin
      hold_id <= evt.task_id;
    end
    if (push) begin
      res.fired_task  <= hold_id;
      res.last_of_run <= evt.flush;
    end
  end

  `PTT_ASSERT_NXT(a_flush_empties_hold, clk, rst, evt.valid && evt.flush && evt_ready, !hold_valid, "hold not emptied by flush")

endmodule

>>> hw/rtl/ptt_seq.sv
`include "periodic_task_timer_table_macros.svh"

module ptt_seq #(
  parameter int TASK_SLOTS = ptt_pkg::TASK_SLOTS_DEF,
  parameter int TIME_BITS  = ptt_pkg::TIME_BITS_DEF,
  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
  localparam int CNT_W = $clog2(TASK_SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  ptt_pkg::cmd_word_t           cmd,
  output logic                         order_we,
  output logic [IDX_W-1:0]             order_waddr,
  output logic [ptt_pkg::ID_W-1:0]     order_wdata,
  output logic                         order_re,
  output logic [IDX_W-1:0]             order_raddr,
  input  logic [ptt_pkg::ID_W-1:0]     order_rdata,
  output logic                         task_we,
  output logic [ptt_pkg::ID_W-1:0]     task_waddr,
  output logic [2*TIME_BITS-1:0]       task_wdata,
  output logic                         task_re,
  output logic [ptt_pkg::ID_W-1:0]     task_raddr,
  input  logic [2*TIME_BITS-1:0]       task_rdata,
  output ptt_pkg::evt_t                evt,
  input  logic                         evt_ready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DROP   = 5'b00010,
    S_APPEND = 5'b00100,
    S_TICK   = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic [CNT_W-1:0]           cnt, cnt_next;
  logic [CNT_W-1:0]           idx, idx_next;
  logic                       b_valid, b_valid_next;
  logic                       c_valid, c_valid_next;
  logic                       found, found_next;
  logic [IDX_W-1:0]           b_idx;
  logic [ptt_pkg::ID_W-1:0]   c_id;
  logic [ptt_pkg::FUNC_W-1:0] func_r;
  logic [ptt_pkg::ID_W-1:0]   id_r;
  logic [TIME_BITS-1:0]       period_r;
  logic [TIME_BITS-1:0]       now_r;

  logic                       issue;
  logic [TIME_BITS-1:0]       c_per;
  logic [TIME_BITS-1:0]       c_last;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       c_fire;
  logic                       advance;

  assign issue   = idx < cnt;
  assign c_per   = task_rdata[2*TIME_BITS-1:TIME_BITS];
  assign c_last  = task_rdata[TIME_BITS-1:0];
  assign elapsed = now_r - c_last;
  assign c_fire  = c_valid && (elapsed >= c_per);
  assign advance = !(c_fire && !evt_ready);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    b_valid_next = b_valid;
    c_valid_next = c_valid;
    found_next   = found;
    cmd_stall    = (state != S_IDLE);
    order_we     = 1'b0;
    order_waddr  = '0;
    order_wdata  = '0;
    order_re     = 1'b0;
    order_raddr  = idx[IDX_W-1:0];
    task_we      = 1'b0;
    task_waddr   = c_id;
    task_wdata   = {c_per, now_r};
    task_re      = 1'b0;
    task_raddr   = order_rdata;
    evt          = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          idx_next     = '0;
          b_valid_next = 1'b0;
          c_valid_next = 1'b0;
          found_next   = 1'b0;
          case (cmd.func) inside
            ptt_pkg::FUNC_ADD, ptt_pkg::FUNC_REMOVE: state_next = S_DROP;
            ptt_pkg::FUNC_TICK:                      state_next = S_TICK;
            default:                                 state_next = S_IDLE;
          endcase
        end
      end

      // Walk the list, find the id, shift the tail down by one.
      S_DROP: begin
        if (issue) begin
          order_re = 1'b1;
          idx_next = idx + 1'b1;
        end
        b_valid_next = issue;
        if (b_valid) begin
          if (found) begin
            order_we    = 1'b1;
            order_waddr = b_idx - 1'b1;
            order_wdata = order_rdata;
          end else if (order_rdata == id_r) begin
            found_next = 1'b1;
          end
        end
        if (!issue && !b_valid) begin
          cnt_next   = cnt - CNT_W'(found);
          state_next = (func_r == ptt_pkg::FUNC_ADD) ? S_APPEND : S_IDLE;
        end
      end

      S_APPEND: begin
        if (cnt < CNT_W'(TASK_SLOTS)) begin
          order_we    = 1'b1;
          order_waddr = cnt[IDX_W-1:0];
          order_wdata = id_r;
          task_we     = 1'b1;
          task_waddr  = id_r;
          task_wdata  = {period_r, now_r - period_r};
          cnt_next    = cnt + 1'b1;
        end
        state_next = S_IDLE;
      end

      // Three stages: order read, task read, compare and write back.
      S_TICK: begin
        evt.valid   = c_fire;
        evt.flush   = 1'b0;
        evt.task_id = c_id;
        if (advance) begin
          if (issue) begin
            order_re = 1'b1;
            idx_next = idx + 1'b1;
          end
          b_valid_next = issue;
          task_re      = b_valid;
          c_valid_next = b_valid;
          task_we      = c_fire;
        end
        if (!issue && !b_valid && !c_valid) begin
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        evt.valid = 1'b1;
        evt.flush = 1'b1;
        if (evt_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      idx     <= '0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      idx     <= idx_next;
      b_valid <= b_valid_next;
      c_valid <= c_valid_next;
      found   <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      func_r   <= cmd.func;
      id_r     <= cmd.task_id;
      period_r <= TIME_BITS'(cmd.period);
      now_r    <= TIME_BITS'(cmd.now);
    end
    if (order_re) begin
      b_idx <= order_raddr;
    end
    if (task_re) begin
      c_id <= order_rdata;
    end
  end

  `PTT_ASSERT_IMP(a_task_rw_distinct, clk, rst, task_we && task_re, task_waddr != task_raddr, "task entry read and written together")
  `PTT_ASSERT_NXT(a_idle_count_holds, clk, rst, state == S_IDLE, $stable(cnt), "task count moved while idle")
  `PTT_ASSERT_NXT(a_stall_freezes_scan, clk, rst, state == S_TICK && !advance, $stable(idx) && $stable(c_id), "scan moved under stall")

endmodule

>>> hw/rtl/periodic_task_timer_table.sv
// Channel  Word                     Valid       Stall       Moves
// cmd      ptt_pkg::cmd_word_t      cmd_valid   cmd_stall   add, remove or tick command
// res      ptt_pkg::res_word_t      res_valid   res_stall   one word per fired task
//
// One command at a time; cmd_stall is high until the command is done.
// Add/remove and tick walk the order list through the single read port of the order-list
// memory, one entry a cycle; a tick scan pauses while the output stalls.
// Reset (rst, synchronous) empties the list; task times are kept in memory without reset.
// res_stall back-pressures the tick scan through a one-word output register.
module periodic_task_timer_table #(
  parameter int TASK_SLOTS = ptt_pkg::TASK_SLOTS_DEF,
  parameter int TIME_BITS  = ptt_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  ptt_pkg::cmd_word_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output ptt_pkg::res_word_t res
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic                     order_we;
  logic [IDX_W-1:0]         order_waddr;
  logic [ptt_pkg::ID_W-1:0] order_wdata;
  logic                     order_re;
  logic [IDX_W-1:0]         order_raddr;
  logic [ptt_pkg::ID_W-1:0] order_rdata;
  logic                     task_we;
  logic [ptt_pkg::ID_W-1:0] task_waddr;
  logic [2*TIME_BITS-1:0]   task_wdata;
  logic                     task_re;
  logic [ptt_pkg::ID_W-1:0] task_raddr;
  logic [2*TIME_BITS-1:0]   task_rdata;
  ptt_pkg::evt_t            evt;
  logic                     evt_ready;

  ptt_seq #(
    .TASK_SLOTS(TASK_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .order_we   (order_we),
    .order_waddr(order_waddr),
    .order_wdata(order_wdata),
    .order_re   (order_re),
    .order_raddr(order_raddr),
    .order_rdata(order_rdata),
    .task_we    (task_we),
    .task_waddr (task_waddr),
    .task_wdata (task_wdata),
    .task_re    (task_re),
    .task_raddr (task_raddr),
    .task_rdata (task_rdata),
    .evt        (evt),
    .evt_ready  (evt_ready)
  );

  // Order list, one task id per slot.
  ptt_ram #(
    .DEPTH(TASK_SLOTS),
    .WIDTH(ptt_pkg::ID_W)
  ) u_order_ram (
    .clk  (clk),
    .we   (order_we),
    .waddr(order_waddr),
    .wdata(order_wdata),
    .re   (order_re),
    .raddr(order_raddr),
    .rdata(order_rdata)
  );

  // Per-id {period, last fire time}.
  ptt_ram #(
    .DEPTH(ptt_pkg::ID_COUNT),
    .WIDTH(2 * TIME_BITS)
  ) u_task_ram (
    .clk  (clk),
    .we   (task_we),
    .waddr(task_waddr),
    .wdata(task_wdata),
    .re   (task_re),
    .raddr(task_raddr),
    .rdata(task_rdata)
  );

  ptt_out u_out (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .evt_ready(evt_ready),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

>>> tb/periodic_task_timer_table_tb.sv
`timescale 1ns / 100ps

module periodic_task_timer_table_tb;
  import ptt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int SLOTS = TASK_SLOTS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_word_t cmd;
  logic res_valid;
  logic res_stall;
  res_word_t res;

  periodic_task_timer_table DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // table model
  logic [ID_W-1:0] tbl_order [SLOTS];
  int tbl_count;
  logic [31:0] tbl_period [ID_COUNT];
  logic [31:0] tbl_last [ID_COUNT];
  res_word_t fires_due [$];

  int mismatches;
  int quiet;
  bit gaps_on;
  bit hold_req;

  task automatic tbl_drop(input logic [ID_W-1:0] id);
    int i;
    int j;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_order[i] == id) begin
        for (j = i; j + 1 < tbl_count; j++) tbl_order[j] = tbl_order[j + 1];
        tbl_count--;
        return;
      end
    end
  endtask

  task automatic tbl_apply(input cmd_word_t w);
    int i;
    int n;
    logic [ID_W-1:0] t;
    logic [31:0] elapsed;
    res_word_t r;
    n = 0;
    case (w.func)
      FUNC_ADD: begin
        tbl_drop(w.task_id);
        if (tbl_count < SLOTS) begin
          tbl_order[tbl_count] = w.task_id;
          tbl_count++;
          tbl_period[w.task_id] = w.period;
          tbl_last[w.task_id] = w.now - w.period;
        end
      end
      FUNC_REMOVE: tbl_drop(w.task_id);
      FUNC_TICK: begin
        for (i = 0; i < tbl_count; i++) begin
          t = tbl_order[i];
          elapsed = w.now - tbl_last[t];
          if (elapsed >= tbl_period[t]) begin
            r.fired_task = t;
            r.last_of_run = 1'b0;
            fires_due.push_back(r);
            tbl_last[t] = w.now;
            n++;
          end
        end
        if (n > 0) fires_due[fires_due.size() - 1].last_of_run = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                          input logic [31:0] per, input logic [31:0] now);
    cmd_word_t w;
    w.func = func;
    w.task_id = id;
    w.period = per;
    w.now = now;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      cmd_valid <= 1'b0;
      cmd <= cmd_word_t'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (cmd_stall);
    tbl_apply(w);
  endtask

  task automatic cmd_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // receiver side
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_stall <= gaps_on && ($urandom_range(0, 99) < 37);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (fires_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: task %0d last %0b", res.fired_task, res.last_of_run);
      end else begin
        want = fires_due.pop_front();
        if (res.fired_task !== want.fired_task || res.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected task %0d last %0b, got task %0d last %0b",
                     want.fired_task, want.last_of_run, res.fired_task, res.last_of_run);
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_cmd(FUNC_TICK, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(FUNC_REMOVE, 4'd3, 32'd0, 32'd0);
    send_cmd(FUNC_SPARE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_field_extremes();
    send_cmd(FUNC_ADD, 4'd0, 32'd0, 32'd0);
    send_cmd(FUNC_ADD, 4'd15, 32'hFFFF_FFFF, 32'd5);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'd5);
    send_cmd(FUNC_TICK, 4'd15, 32'hFFFF_FFFF, 32'd4);
    send_cmd(FUNC_ADD, 4'd3, 32'd100, 32'hFFFF_FFF0);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'hFFFF_FFF8);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'h0000_0050);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'h0000_0060);
  endtask

  task automatic test_list_order();
    send_cmd(FUNC_ADD, 4'd7, 32'd1, 32'h0000_1000);
    send_cmd(FUNC_ADD, 4'd0, 32'd2, 32'h0000_1000);
    send_cmd(FUNC_REMOVE, 4'd15, 32'd0, 32'd0);
    send_cmd(FUNC_REMOVE, 4'd15, 32'd0, 32'd0);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'h0000_1000);
    send_cmd(FUNC_SPARE, 4'd0, 32'd0, 32'd0);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'h0000_1002);
  endtask

  task automatic test_full_table_backpressure();
    int id;
    hold_req = 1'b1;
    for (id = 0; id < ID_COUNT; id++) send_cmd(FUNC_ADD, ID_W'(id), 32'd0, $urandom);
    send_cmd(FUNC_TICK, ID_W'($urandom), $urandom, $urandom);
    send_cmd(FUNC_TICK, ID_W'($urandom), $urandom, $urandom);
    send_cmd(FUNC_ADD, 4'd5, 32'd10, 32'd0);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'd9);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 32'd10);
  endtask

  task automatic test_random_traffic(input int n_items);
    int k;
    int pick;
    logic [31:0] t_base;
    t_base = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FE00;
    gaps_on = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (k == 40) gaps_on = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_cmd(FUNC_ADD, ID_W'($urandom_range(0, 15)), rand_period(),
                 ($urandom_range(0, 4) == 0) ? $urandom : t_base);
      end else if (pick < 50) begin
        send_cmd(FUNC_REMOVE, ID_W'($urandom_range(0, 15)), $urandom, $urandom);
      end else if (pick < 95) begin
        if ($urandom_range(0, 9) == 0) t_base = $urandom;
        else t_base = t_base + $urandom_range(0, 150);
        send_cmd(FUNC_TICK, ID_W'($urandom_range(0, 15)), $urandom, t_base);
      end else begin
        send_cmd(FUNC_SPARE, ID_W'($urandom_range(0, 15)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    mismatches = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    tbl_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_field_extremes();
    test_list_order();
    test_full_table_backpressure();
    test_random_traffic(120);
    cmd_idle();

    while (fires_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && fires_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
